@@ src/fub_pkg.sv @@
// Shared constants and types for the flow uplink balancer.
package fub_pkg;

  localparam int FLOW_ENTRIES = 64;
  localparam int MAX_PORTS    = 16;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int PORT_W       = 4;
  localparam int RADIX_W      = 5;
  localparam int KEY_W        = 64;
  localparam int CNT64_W      = 64;
  localparam int PKT_W        = 16;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd4;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_PORTS);

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // one flow table word
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CNT64_W-1:0] bytes;
    logic [PORT_W-1:0]  port;
  } flow_entry_t;

endpackage

@@ src/flow_uplink_balancer.sv @@
// Flow uplink balancer: sticky flow table and periodic uplink rebalancing.
// A known flow takes a table sweep through the registered-read flow memory,
// then a load read-modify-write; a new flow adds a sweep of the uplink load
// memory. A tick takes up to k passes of a load sweep plus a table sweep.
// One item at a time; out_valid strobes for one cycle.
// Reset clears flow valid bits, load valid bits and config (port_count = 4).
module flow_uplink_balancer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [fub_pkg::KEY_W-1:0]     in_flow_key,
  input  logic [fub_pkg::PKT_W-1:0]     in_packet_bytes,
  output logic                          out_valid,
  output logic [fub_pkg::PORT_W-1:0]    out_port,
  output logic                          out_new_flow,
  output logic                          out_table_full,
  output logic [fub_pkg::RADIX_W-1:0]   out_flows_moved,
  input  logic                          cfg_we,
  input  logic [fub_pkg::RADIX_W-1:0]   cfg_wdata
);
  import fub_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK, S_HRD, S_HWR, S_LS, S_PW, S_TS, S_TW1, S_TW2, S_TEND
  } state_t;

  state_t state_r;

  logic [RADIX_W-1:0]  pc_r;
  logic [RADIX_W-1:0]  k;
  logic [PORT_W-1:0]   half;

  logic                kind_r;
  logic [KEY_W-1:0]    key_r;
  logic [PKT_W-1:0]    bytes_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [RADIX_W-1:0]  pass_r;
  logic [RADIX_W-1:0]  moved_r;

  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [CNT64_W-1:0]  hit_bytes_r;
  logic [PORT_W-1:0]   hit_port_r;

  logic [CNT64_W-1:0]  lmax_r, lmin_r, diff_r;
  logic [PORT_W-1:0]   pmax_r, pmin_r;
  logic                found_r;
  logic [IDX_W-1:0]    bidx_r;
  logic [CNT64_W-1:0]  bsize_r;
  logic [KEY_W-1:0]    bkey_r;

  logic                ev_r [FLOW_ENTRIES];
  logic                bz_r [FLOW_ENTRIES];
  logic                lv_r [MAX_PORTS];

  // flow table memory
  flow_entry_t         tab_mem [FLOW_ENTRIES];
  flow_entry_t         tab_q;
  logic [IDX_W-1:0]    tab_ra, tab_wa, taq_r;
  logic                tab_re, tab_we, trv_r;
  flow_entry_t         tab_wd;

  // uplink load memory
  logic [CNT64_W-1:0]  ld_mem [MAX_PORTS];
  logic [CNT64_W-1:0]  ld_q, ld_wd;
  logic [PORT_W-1:0]   ld_ra, ld_wa, laq_r;
  logic                ld_re, ld_we, lrv_r;

  logic [CNT64_W-1:0]  eff_bytes, eff_load, pkt64;
  logic                key_hit;
  logic                cand;

  // saturated radix and first uplink
  always_comb begin
    if (pc_r < RADIX_MIN) k = RADIX_MIN;
    else if (pc_r > RADIX_MAX) k = RADIX_MAX;
    else k = pc_r;
    half = PORT_W'(k >> 1);
  end

  assign pkt64     = CNT64_W'(bytes_r);
  assign eff_bytes = bz_r[taq_r] ? '0 : tab_q.bytes;
  assign eff_load  = lv_r[laq_r] ? ld_q : '0;
  assign key_hit   = ev_r[taq_r] && (tab_q.key == key_r);
  assign cand      = ev_r[taq_r] && (tab_q.port == pmax_r) && (eff_bytes != '0) &&
                     (eff_bytes < diff_r) &&
                     (!found_r || (eff_bytes > bsize_r) ||
                      ((eff_bytes == bsize_r) && (tab_q.key < bkey_r)));

  // read address and write port selection
  always_comb begin
    tab_ra = cnt_r[IDX_W-1:0];
    tab_re = ((state_r == S_LK) || (state_r == S_TS)) && (cnt_r < CNT_W'(FLOW_ENTRIES));
    ld_ra  = (state_r == S_HRD) ? hit_port_r : cnt_r[PORT_W-1:0];
    ld_re  = ((state_r == S_LS) && (cnt_r < CNT_W'(k))) || (state_r == S_HRD);
    tab_we = 1'b0;
    tab_wa = hit_idx_r;
    tab_wd = '{key: key_r, bytes: hit_bytes_r + pkt64, port: hit_port_r};
    ld_we  = 1'b0;
    ld_wa  = hit_port_r;
    ld_wd  = eff_load + pkt64;
    case (state_r)
      S_HWR: begin
        tab_we = 1'b1;
        ld_we  = 1'b1;
      end
      S_PW: begin
        tab_we = free_found_r;
        tab_wa = free_idx_r;
        tab_wd = '{key: key_r, bytes: pkt64, port: pmin_r};
        ld_we  = 1'b1;
        ld_wa  = pmin_r;
        ld_wd  = lmin_r + pkt64;
      end
      S_TW1: begin
        tab_we = 1'b1;
        tab_wa = bidx_r;
        tab_wd = '{key: bkey_r, bytes: bsize_r, port: pmin_r};
        ld_we  = 1'b1;
        ld_wa  = pmax_r;
        ld_wd  = lmax_r - bsize_r;
      end
      S_TW2: begin
        ld_we  = 1'b1;
        ld_wa  = pmin_r;
        ld_wd  = lmin_r + bsize_r;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_q <= tab_mem[tab_ra];
    taq_r <= tab_ra;
    if (ld_we) ld_mem[ld_wa] <= ld_wd;
    ld_q  <= ld_mem[ld_ra];
    laq_r <= ld_ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trv_r <= 1'b0;
      lrv_r <= 1'b0;
    end else begin
      trv_r <= tab_re;
      lrv_r <= ld_re;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= RADIX_RESET;
    else if (cfg_we) pc_r <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        ev_r[i] <= 1'b0;
        bz_r[i] <= 1'b0;
      end
      for (int p = 0; p < MAX_PORTS; p++) lv_r[p] <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (ld_we) lv_r[ld_wa] <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r       <= in_kind;
            key_r        <= in_flow_key;
            bytes_r      <= in_packet_bytes;
            free_found_r <= 1'b0;
            pass_r       <= '0;
            moved_r      <= '0;
            if (in_kind == KIND_TICK) begin
              cnt_r   <= CNT_W'(half);
              lmax_r  <= '0;
              lmin_r  <= '1;
              pmax_r  <= half;
              pmin_r  <= half;
              state_r <= S_LS;
            end else begin
              cnt_r   <= '0;
              state_r <= S_LK;
            end
          end
        end
        // sweep the table for the key, note the first free entry
        S_LK: begin
          if (tab_re) cnt_r <= cnt_r + 1'b1;
          if (trv_r && key_hit) begin
            hit_idx_r   <= taq_r;
            hit_bytes_r <= eff_bytes;
            hit_port_r  <= tab_q.port;
            state_r     <= S_HRD;
          end else begin
            if (trv_r && !ev_r[taq_r] && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= taq_r;
            end
            if (!tab_re && !trv_r) begin
              cnt_r   <= CNT_W'(half);
              lmin_r  <= '1;
              pmin_r  <= half;
              state_r <= S_LS;
            end
          end
        end
        S_HRD: state_r <= S_HWR;
        S_HWR: begin
          bz_r[hit_idx_r] <= 1'b0;
          out_valid       <= 1'b1;
          out_port        <= hit_port_r;
          out_new_flow    <= 1'b0;
          out_table_full  <= 1'b0;
          out_flows_moved <= '0;
          state_r         <= S_IDLE;
        end
        // sweep uplink loads: idlest (first) and busiest (last)
        S_LS: begin
          if (ld_re) cnt_r <= cnt_r + 1'b1;
          if (lrv_r) begin
            if (eff_load < lmin_r) begin
              lmin_r <= eff_load;
              pmin_r <= laq_r;
            end
            if (eff_load >= lmax_r) begin
              lmax_r <= eff_load;
              pmax_r <= laq_r;
            end
          end
          if (!ld_re && !lrv_r) begin
            if (kind_r == KIND_PACKET) state_r <= S_PW;
            else if (lmax_r <= lmin_r) state_r <= S_TEND;
            else begin
              diff_r  <= lmax_r - lmin_r;
              cnt_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_TS;
            end
          end
        end
        S_PW: begin
          if (free_found_r) begin
            ev_r[free_idx_r] <= 1'b1;
            bz_r[free_idx_r] <= 1'b0;
          end
          out_valid       <= 1'b1;
          out_port        <= pmin_r;
          out_new_flow    <= 1'b1;
          out_table_full  <= !free_found_r;
          out_flows_moved <= '0;
          state_r         <= S_IDLE;
        end
        // sweep table for the flow to move
        S_TS: begin
          if (tab_re) cnt_r <= cnt_r + 1'b1;
          if (trv_r && cand) begin
            found_r <= 1'b1;
            bidx_r  <= taq_r;
            bsize_r <= eff_bytes;
            bkey_r  <= tab_q.key;
          end
          if (!tab_re && !trv_r) state_r <= found_r ? S_TW1 : S_TEND;
        end
        S_TW1: state_r <= S_TW2;
        S_TW2: begin
          moved_r <= moved_r + 1'b1;
          pass_r  <= pass_r + 1'b1;
          if ((pass_r + 1'b1) < k) begin
            cnt_r   <= CNT_W'(half);
            lmax_r  <= '0;
            lmin_r  <= '1;
            pmax_r  <= half;
            pmin_r  <= half;
            state_r <= S_LS;
          end else begin
            state_r <= S_TEND;
          end
        end
        // clear all byte counts and loads
        S_TEND: begin
          for (int i = 0; i < FLOW_ENTRIES; i++) bz_r[i] <= 1'b1;
          for (int p = 0; p < MAX_PORTS; p++) lv_r[p] <= 1'b0;
          out_valid       <= 1'b1;
          out_port        <= '0;
          out_new_flow    <= 1'b0;
          out_table_full  <= 1'b0;
          out_flows_moved <= moved_r;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  // checks
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result word while busy");
  a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> out_new_flow) else $error("full without new flow");
  a_tick_port: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flows_moved != '0) |-> (out_port == '0 && !out_new_flow))
    else $error("tick word carries packet fields");
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two result words for one item");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the flow uplink balancer: directed table, then random traffic.
module tb_top;
  import fub_pkg::*;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [PORT_W-1:0]  port;
    logic               newf;
    logic               full;
    logic [RADIX_W-1:0] moved;
  } route_t;

  // one row of the directed table
  typedef struct {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [PKT_W-1:0]   bytes;
    bit                 typed;
    route_t             res;
  } stim_row_t;

  localparam int DIR_ROWS = 18;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = KIND_PACKET;
  logic [KEY_W-1:0] in_flow_key = '0;
  logic [PKT_W-1:0] in_packet_bytes = '0;
  logic out_valid;
  logic [PORT_W-1:0] out_port;
  logic out_new_flow;
  logic out_table_full;
  logic [RADIX_W-1:0] out_flows_moved;
  logic cfg_we = 1'b0;
  logic [RADIX_W-1:0] cfg_wdata = '0;

  flow_uplink_balancer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_flow_key(in_flow_key), .in_packet_bytes(in_packet_bytes),
    .out_valid(out_valid), .out_port(out_port), .out_new_flow(out_new_flow),
    .out_table_full(out_table_full), .out_flows_moved(out_flows_moved),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end

  // shadow copy of the block's state
  logic [RADIX_W-1:0] sh_radix = RADIX_RESET;
  bit                 sh_valid [FLOW_ENTRIES];
  logic [KEY_W-1:0]   sh_key   [FLOW_ENTRIES];
  logic [CNT64_W-1:0] sh_bytes [FLOW_ENTRIES];
  logic [PORT_W-1:0]  sh_port  [FLOW_ENTRIES];
  logic [CNT64_W-1:0] sh_load  [MAX_PORTS];

  route_t route_q[$];
  int errs = 0;

  function automatic int eff_radix();
    int k;
    k = sh_radix;
    if (k < 2) k = 2;
    if (k > MAX_PORTS) k = MAX_PORTS;
    return k;
  endfunction

  // packet: sticky lookup, else least-loaded uplink
  function automatic route_t route_packet(logic [KEY_W-1:0] key, logic [PKT_W-1:0] bytes);
    route_t r;
    int k, half, free_slot, best;
    logic [CNT64_W-1:0] best_load;
    k = eff_radix();
    half = k / 2;
    free_slot = -1;
    r = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (sh_valid[i] && sh_key[i] == key) begin
        sh_bytes[i] += CNT64_W'(bytes);
        sh_load[sh_port[i]] += CNT64_W'(bytes);
        r.port = sh_port[i];
        return r;
      end
      if (!sh_valid[i] && free_slot < 0) free_slot = i;
    end
    best = half;
    best_load = '1;
    for (int p = half; p < k; p++) begin
      if (sh_load[p] < best_load) begin
        best_load = sh_load[p];
        best = p;
      end
    end
    r.port = PORT_W'(best);
    r.newf = 1'b1;
    if (free_slot >= 0) begin
      sh_valid[free_slot] = 1'b1;
      sh_key[free_slot] = key;
      sh_bytes[free_slot] = CNT64_W'(bytes);
      sh_port[free_slot] = PORT_W'(best);
    end else begin
      r.full = 1'b1;
    end
    sh_load[best] += CNT64_W'(bytes);
    return r;
  endfunction

  // tick: up to k moves from busiest to idlest uplink, then clear counters
  function automatic route_t rebalance_tick();
    route_t r;
    int k, half, pmax, pmin, bidx, moved;
    logic [CNT64_W-1:0] lmax, lmin, diff, bsize, b;
    k = eff_radix();
    half = k / 2;
    moved = 0;
    r = '0;
    for (int pass = 0; pass < k; pass++) begin
      pmax = half; pmin = half;
      lmax = '0; lmin = '1; bsize = '0; bidx = -1;
      for (int p = half; p < k; p++) begin
        if (sh_load[p] >= lmax) begin lmax = sh_load[p]; pmax = p; end
        if (sh_load[p] < lmin) begin lmin = sh_load[p]; pmin = p; end
      end
      if (lmax <= lmin) break;
      diff = lmax - lmin;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        b = sh_bytes[i];
        if (!sh_valid[i] || sh_port[i] != PORT_W'(pmax)) continue;
        if (b == 0 || b >= diff) continue;
        if (bidx < 0 || b > bsize || (b == bsize && sh_key[i] < sh_key[bidx])) begin
          bidx = i;
          bsize = b;
        end
      end
      if (bidx < 0) break;
      sh_port[bidx] = PORT_W'(pmin);
      sh_load[pmax] -= bsize;
      sh_load[pmin] += bsize;
      moved++;
    end
    for (int i = 0; i < FLOW_ENTRIES; i++) sh_bytes[i] = '0;
    for (int p = 0; p < MAX_PORTS; p++) sh_load[p] = '0;
    r.moved = RADIX_W'(moved);
    return r;
  endfunction

  // present one word and hold it until accepted; start is left high
  task automatic send_word(logic kind, logic [KEY_W-1:0] key, logic [PKT_W-1:0] bytes,
                           bit typed, route_t typed_res);
    route_t r;
    start <= 1'b1;
    in_kind <= kind;
    in_flow_key <= key;
    in_packet_bytes <= bytes;
    do @(posedge clk); while (busy);
    if (kind == KIND_TICK) r = rebalance_tick();
    else r = route_packet(key, bytes);
    route_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (route_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_radix = v;
  endtask

  // result checker
  always @(posedge clk) begin
    route_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_port, out_new_flow, out_table_full, out_flows_moved};
      if (route_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected word: port %0d new %0b full %0b moved %0d",
                                 got.port, got.newf, got.full, got.moved);
      end else begin
        want = route_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10)
            $display("word mismatch: exp port %0d new %0b full %0b moved %0d, got %0d %0b %0b %0d",
                     want.port, want.newf, want.full, want.moved,
                     got.port, got.newf, got.full, got.moved);
        end
      end
    end
  end

  stim_row_t dir_rows [DIR_ROWS];
  logic [KEY_W-1:0] key_pool [40];
  logic [RADIX_W-1:0] phase_radix [10] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd3,
                                          5'd17, 5'd1, 5'd7, 5'd16, 5'd5};

  initial begin
    logic [KEY_W-1:0] key;
    logic [PKT_W-1:0] bytes;
    logic kind;
    int n, total, fresh_pct;

    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      sh_valid[i] = 1'b0; sh_key[i] = '0; sh_bytes[i] = '0; sh_port[i] = '0;
    end
    for (int p = 0; p < MAX_PORTS; p++) sh_load[p] = '0;
    for (int i = 0; i < 40; i++) key_pool[i] = {$urandom(), $urandom()};

    // radix 4 after reset: uplinks 2 and 3
    dir_rows = '{
      '{KIND_PACKET, 64'h0, 16'hFFFF, 1'b1, '{4'd2, 1'b1, 1'b0, 5'd0}},
      '{KIND_PACKET, '1, 16'h0, 1'b1, '{4'd3, 1'b1, 1'b0, 5'd0}},
      '{KIND_TICK, 64'h0, 16'h0, 1'b1, '{4'd0, 1'b0, 1'b0, 5'd0}},
      '{KIND_PACKET, 64'h0, 16'd100, 1'b1, '{4'd2, 1'b0, 1'b0, 5'd0}},
      '{KIND_PACKET, 64'h1, 16'd5, 1'b1, '{4'd3, 1'b1, 1'b0, 5'd0}},
      '{KIND_PACKET, 64'h2, 16'd7, 1'b0, '0},
      '{KIND_PACKET, 64'h3, 16'd40, 1'b0, '0},
      '{KIND_TICK, 64'h0, 16'h0, 1'b0, '0},
      '{KIND_PACKET, 64'h0, 16'hFFFF, 1'b0, '0},
      '{KIND_PACKET, '1, 16'hFFFF, 1'b0, '0},
      '{KIND_PACKET, 64'hAAAA_AAAA_AAAA_AAAA, 16'd1, 1'b0, '0},
      '{KIND_PACKET, 64'h5555_5555_5555_5555, 16'hFFFE, 1'b0, '0},
      // tick ignores its key and byte fields
      '{KIND_TICK, 64'hDEAD, 16'd999, 1'b0, '0},
      '{KIND_PACKET, 64'h1, 16'h0, 1'b0, '0},
      '{KIND_TICK, 64'h0, 16'h0, 1'b0, '0},
      '{KIND_TICK, '1, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b0, 5'd0}},
      '{KIND_PACKET, 64'h8000_0000_0000_0000, 16'h8000, 1'b0, '0},
      '{KIND_PACKET, 64'h0000_0001_0000_0000, 16'd1, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].bytes,
                dir_rows[i].typed, dir_rows[i].res);
    drain();

    total = 0;
    for (int ph = 0; ph < 10; ph++) begin
      write_radix(ph == 9 ? RADIX_W'($urandom_range(0, 31)) : phase_radix[ph]);
      n = 115;
      fresh_pct = (ph < 5) ? 2 : 15;
      for (int j = 0; j < n; j++) begin
        kind = ($urandom_range(0, 99) < 6) ? KIND_TICK : KIND_PACKET;
        if ($urandom_range(0, 99) < fresh_pct) key = {$urandom(), $urandom()};
        else key = key_pool[$urandom_range(0, 39)];
        case ($urandom_range(0, 19))
          0, 1:    bytes = '0;
          2:       bytes = '1;
          3, 4, 5: bytes = PKT_W'($urandom_range(1, 64));
          default: bytes = PKT_W'($urandom());
        endcase
        send_word(kind, key, bytes, 1'b0, '0);
        total++;
        // sender gaps, none in the closing stretch
        if (total < 1000 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (route_q.size() != 0) errs++;
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
